/* sv/dlee_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dlee_pkg : shared types and constants of the dual LED effect engine
// Request codes, LED status structures and the fixed-point effect constants.
// ---------------------------------------------------------------------------
package dlee_pkg;

    // request actions
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_COLOUR = 2'd1;
    localparam logic [1:0] ACT_MODE   = 2'd2;

    // LED selection
    localparam logic [1:0] SEL_BOTTOM = 2'd0;
    localparam logic [1:0] SEL_TOP    = 2'd1;
    localparam logic [1:0] SEL_BOTH   = 2'd2;

    // effect modes
    localparam logic [1:0] MODE_STATIC = 2'd0;
    localparam logic [1:0] MODE_CYCLE  = 2'd1;
    localparam logic [1:0] MODE_BREATH = 2'd2;

    // configuration register indexes
    localparam logic CFG_BREATH_PERIOD = 1'b0;
    localparam logic CFG_CYCLE_PERIOD  = 1'b1;

    localparam logic [31:0] PERIOD_RESET = 32'd10000;

    // hue in tenths of a degree
    localparam int          HUE_W           = 12;
    localparam logic [11:0] HUE_STEP_TENTHS = 12'd3;
    localparam logic [11:0] HUE_WRAP_TENTHS = 12'd3610;
    localparam logic [11:0] SECTOR_TENTHS   = 12'd600;

    // brightness in hundredths
    localparam logic [6:0] LEVEL_FULL = 7'd100;
    localparam logic [7:0] CHAN_FULL  = 8'd255;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] target;
        logic [1:0] new_mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t       colour;
        logic [6:0] level;
    } led_t;

    typedef struct packed {
        led_t top_led;
        led_t bottom_led;
    } status_t;

    typedef struct packed {
        logic       down;
        logic [6:0] level;
    } breath_t;

endpackage

`default_nettype wire

/* sv/dlee_hue_colour.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dlee_hue_colour : full-saturation hue to RGB conversion
// Picks the 60 degree sector by compares and scales the ramp to 0..255.
// ---------------------------------------------------------------------------
module dlee_hue_colour (
    input  wire logic [11:0]   hue,
    output dlee_pkg::rgb_t     colour
);

    logic [2:0]  sector;
    logic [11:0] base;
    logic [9:0]  ramp;
    logic [13:0] scaled;
    logic [10:0] eighths;
    logic [20:0] recip;
    logic [7:0]  x;

    // sector index, hues at or past the sixth boundary get a seventh index, 6
    always_comb begin
        if (hue < 12'd600) begin
            sector = 3'd0;
        end else if (hue < 12'd1200) begin
            sector = 3'd1;
        end else if (hue < 12'd1800) begin
            sector = 3'd2;
        end else if (hue < 12'd2400) begin
            sector = 3'd3;
        end else if (hue < 12'd3000) begin
            sector = 3'd4;
        end else if (hue < 12'd3600) begin
            sector = 3'd5;
        end else begin
            sector = 3'd6;
        end
    end

    // ramp distance within the sector, mirrored in odd sectors
    always_comb begin
        case (sector)
            3'd0:    base = 12'd0;
            3'd1:    base = 12'd600;
            3'd2:    base = 12'd1200;
            3'd3:    base = 12'd1800;
            3'd4:    base = 12'd2400;
            3'd5:    base = 12'd3000;
            default: base = 12'd3600;
        endcase
        if (sector[0]) begin
            ramp = 10'(base + dlee_pkg::SECTOR_TENTHS - hue);
        end else begin
            ramp = 10'(hue - base);
        end
    end

    // x = (ramp*255 + 300) / 600 = ((17*ramp + 20) / 8) / 5, last step by reciprocal
    always_comb begin
        scaled  = 14'({4'd0, ramp} * 14'd17) + 14'd20;
        eighths = scaled[13:3];
        recip   = 21'({10'd0, eighths} * 21'd1639);
        x       = recip[20:13];
    end

    // channel placement per sector
    always_comb begin
        case (sector)
            3'd0:    colour = '{red: dlee_pkg::CHAN_FULL, green: x, blue: 8'd0};
            3'd1:    colour = '{red: x, green: dlee_pkg::CHAN_FULL, blue: 8'd0};
            3'd2:    colour = '{red: 8'd0, green: dlee_pkg::CHAN_FULL, blue: x};
            3'd3:    colour = '{red: 8'd0, green: x, blue: dlee_pkg::CHAN_FULL};
            3'd4:    colour = '{red: x, green: 8'd0, blue: dlee_pkg::CHAN_FULL};
            default: colour = '{red: dlee_pkg::CHAN_FULL, green: 8'd0, blue: x};
        endcase
    end

endmodule

`default_nettype wire

/* sv/dlee_effect_state.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dlee_effect_state : LED state, interval timers and effect update
// Applies one request per cycle, while fire is high, to the LED state and gives the new status.
// ---------------------------------------------------------------------------
module dlee_effect_state (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire dlee_pkg::req_t   req,
    input  wire logic [31:0]      breath_period,
    input  wire logic [31:0]      cycle_period,
    output dlee_pkg::status_t     status_next
);

    dlee_pkg::rgb_t top_col_reg, top_col_next;
    dlee_pkg::rgb_t bottom_col_reg, bottom_col_next;
    logic [6:0]     top_bright_reg, top_bright_next;
    logic [6:0]     bottom_bright_reg, bottom_bright_next;
    logic [1:0]     top_mode_reg, top_mode_next;
    logic [1:0]     bottom_mode_reg, bottom_mode_next;
    logic           breath_down_reg, breath_down_next;
    logic [11:0]    hue_reg, hue_next;
    logic [31:0]    breath_elapsed_reg, breath_elapsed_next;
    logic [31:0]    cycle_elapsed_reg, cycle_elapsed_next;

    logic [31:0]       breath_inc, cycle_inc;
    logic [11:0]       hue_sum, hue_step;
    dlee_pkg::rgb_t    hue_rgb;
    logic [6:0]        breath_src;
    dlee_pkg::breath_t breath_res;
    logic              breath_on, cycle_on;

    // one breath step; level stays within 1..99 once running
    function automatic dlee_pkg::breath_t breath_advance(input logic [6:0] b, input logic down);
        dlee_pkg::breath_t r;
        if (!down) begin
            if (b >= 7'd99) begin
                r.down  = 1'b1;
                r.level = b - 7'd1;
            end else begin
                r.down  = 1'b0;
                r.level = b + 7'd1;
            end
        end else begin
            if (b <= 7'd1) begin
                r.down  = 1'b0;
                r.level = b + 7'd1;
            end else begin
                r.down  = 1'b1;
                r.level = b - 7'd1;
            end
        end
        return r;
    endfunction

    // next hue, wrapped
    always_comb begin
        hue_sum = hue_reg + dlee_pkg::HUE_STEP_TENTHS;
        if (hue_sum >= dlee_pkg::HUE_WRAP_TENTHS) begin
            hue_step = hue_sum - dlee_pkg::HUE_WRAP_TENTHS;
        end else begin
            hue_step = hue_sum;
        end
    end

    dlee_hue_colour u_hue_colour (
        .hue    (hue_step),
        .colour (hue_rgb)
    );

    // breath source: top brightness unless only the bottom LED breathes
    always_comb begin
        breath_src = (top_mode_reg == dlee_pkg::MODE_BREATH) ? top_bright_reg
                                                             : bottom_bright_reg;
        breath_res = breath_advance(breath_src, breath_down_reg);
        breath_on  = (top_mode_reg == dlee_pkg::MODE_BREATH) ||
                     (bottom_mode_reg == dlee_pkg::MODE_BREATH);
        cycle_on   = (top_mode_reg == dlee_pkg::MODE_CYCLE) ||
                     (bottom_mode_reg == dlee_pkg::MODE_CYCLE);
        breath_inc = breath_elapsed_reg + 32'd1;
        cycle_inc  = cycle_elapsed_reg + 32'd1;
    end

    // request decode and effect update
    always_comb begin
        top_col_next        = top_col_reg;
        bottom_col_next     = bottom_col_reg;
        top_bright_next     = top_bright_reg;
        bottom_bright_next  = bottom_bright_reg;
        top_mode_next       = top_mode_reg;
        bottom_mode_next    = bottom_mode_reg;
        breath_down_next    = breath_down_reg;
        hue_next            = hue_reg;
        breath_elapsed_next = breath_elapsed_reg;
        cycle_elapsed_next  = cycle_elapsed_reg;
        if (fire) begin
            case (req.action)
                dlee_pkg::ACT_TICK: begin
                    breath_elapsed_next = breath_inc;
                    cycle_elapsed_next  = cycle_inc;
                    if (top_mode_reg == dlee_pkg::MODE_STATIC) begin
                        top_bright_next = dlee_pkg::LEVEL_FULL;
                    end
                    if (bottom_mode_reg == dlee_pkg::MODE_STATIC) begin
                        bottom_bright_next = dlee_pkg::LEVEL_FULL;
                    end
                    if (cycle_on && (cycle_inc >= cycle_period)) begin
                        hue_next           = hue_step;
                        cycle_elapsed_next = '0;
                        if (top_mode_reg == dlee_pkg::MODE_CYCLE) begin
                            top_col_next = hue_rgb;
                        end
                        if (bottom_mode_reg == dlee_pkg::MODE_CYCLE) begin
                            bottom_col_next = hue_rgb;
                        end
                    end
                    if (breath_on && (breath_inc >= breath_period)) begin
                        breath_down_next    = breath_res.down;
                        breath_elapsed_next = '0;
                        if (top_mode_reg == dlee_pkg::MODE_BREATH) begin
                            top_bright_next = breath_res.level;
                        end
                        if (bottom_mode_reg == dlee_pkg::MODE_BREATH) begin
                            bottom_bright_next = breath_res.level;
                        end
                    end
                end
                dlee_pkg::ACT_COLOUR: begin
                    if (req.target != dlee_pkg::SEL_BOTTOM) begin
                        top_col_next = '{red: req.red, green: req.green, blue: req.blue};
                    end
                    if (req.target != dlee_pkg::SEL_TOP) begin
                        bottom_col_next = '{red: req.red, green: req.green, blue: req.blue};
                    end
                end
                dlee_pkg::ACT_MODE: begin
                    if (req.target != dlee_pkg::SEL_BOTTOM) begin
                        top_mode_next = req.new_mode;
                    end
                    if (req.target != dlee_pkg::SEL_TOP) begin
                        bottom_mode_next = req.new_mode;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign status_next.top_led.colour    = top_col_next;
    assign status_next.top_led.level     = top_bright_next;
    assign status_next.bottom_led.colour = bottom_col_next;
    assign status_next.bottom_led.level  = bottom_bright_next;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_col_reg        <= '0;
            bottom_col_reg     <= '0;
            top_bright_reg     <= dlee_pkg::LEVEL_FULL;
            bottom_bright_reg  <= dlee_pkg::LEVEL_FULL;
            top_mode_reg       <= dlee_pkg::MODE_STATIC;
            bottom_mode_reg    <= dlee_pkg::MODE_STATIC;
            breath_down_reg    <= 1'b0;
            hue_reg            <= '0;
            breath_elapsed_reg <= '0;
            cycle_elapsed_reg  <= '0;
        end else begin
            top_col_reg        <= top_col_next;
            bottom_col_reg     <= bottom_col_next;
            top_bright_reg     <= top_bright_next;
            bottom_bright_reg  <= bottom_bright_next;
            top_mode_reg       <= top_mode_next;
            bottom_mode_reg    <= bottom_mode_next;
            breath_down_reg    <= breath_down_next;
            hue_reg            <= hue_next;
            breath_elapsed_reg <= breath_elapsed_next;
            cycle_elapsed_reg  <= cycle_elapsed_next;
        end
    end

    // hue never reaches the wrap point
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hue_reg < dlee_pkg::HUE_WRAP_TENTHS)
        else $error("hue out of range");

    // brightness stays within full scale
    a_bright_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (top_bright_reg <= dlee_pkg::LEVEL_FULL) && (bottom_bright_reg <= dlee_pkg::LEVEL_FULL))
        else $error("brightness out of range");

    // state only moves on an accepted request
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(hue_reg) && $stable(breath_elapsed_reg) && $stable(top_mode_reg))
        else $error("state changed without a request");

endmodule

`default_nettype wire

/* sv/dual_led_effect_engine_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dual_led_effect_engine_core : top and bottom RGB LED effect engine
// Static, hue cycle and breath effects under two shared interval timers.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    action, target, new_mode, rgb
//  m_        out        m_valid / m_ready    top and bottom rgb and level
//  cfg_      in         cfg_we               cfg_index, cfg_wdata
//
//  one request per cycle sustained while the output is not stalled; a result is
//  valid once its request has passed the input register and then the result register
//  the state update and hue conversion sit in the single stage between them
//  reset clears both registers and loads the LED state; no clearing pass
//  a stalled result holds the update stage, and the input register still
//  takes one more request while the result waits
// ---------------------------------------------------------------------------
module dual_led_effect_engine_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [1:0]  s_target,
    input  wire logic [1:0]  s_new_mode,
    input  wire logic [7:0]  s_red_in,
    input  wire logic [7:0]  s_green_in,
    input  wire logic [7:0]  s_blue_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_top_red,
    output logic [7:0]       m_top_green,
    output logic [7:0]       m_top_blue,
    output logic [6:0]       m_top_level,
    output logic [7:0]       m_bottom_red,
    output logic [7:0]       m_bottom_green,
    output logic [7:0]       m_bottom_blue,
    output logic [6:0]       m_bottom_level,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    logic               in_valid_reg;
    dlee_pkg::req_t     req_reg;
    logic               out_valid_reg;
    dlee_pkg::status_t  status_reg;
    dlee_pkg::status_t  status_next;
    logic [31:0]        breath_period_reg;
    logic [31:0]        cycle_period_reg;
    logic               advance;

    // update stage moves when the result slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            breath_period_reg <= dlee_pkg::PERIOD_RESET;
            cycle_period_reg  <= dlee_pkg::PERIOD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                dlee_pkg::CFG_BREATH_PERIOD: breath_period_reg <= cfg_wdata;
                dlee_pkg::CFG_CYCLE_PERIOD:  cycle_period_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= '{action: s_action, target: s_target, new_mode: s_new_mode,
                         red: s_red_in, green: s_green_in, blue: s_blue_in};
        end
    end

    dlee_effect_state u_state (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (advance),
        .req           (req_reg),
        .breath_period (breath_period_reg),
        .cycle_period  (cycle_period_reg),
        .status_next   (status_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= status_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_top_red      = status_reg.top_led.colour.red;
    assign m_top_green    = status_reg.top_led.colour.green;
    assign m_top_blue     = status_reg.top_led.colour.blue;
    assign m_top_level    = status_reg.top_led.level;
    assign m_bottom_red   = status_reg.bottom_led.colour.red;
    assign m_bottom_green = status_reg.bottom_led.colour.green;
    assign m_bottom_blue  = status_reg.bottom_led.colour.blue;
    assign m_bottom_level = status_reg.bottom_led.level;

    // an update always leaves a result behind
    a_update_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("update without result");

    // input is refused only when both stages are full and the output stalls
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input refused without a stall");

    // an accepted request lands in the input register
    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted request lost");

endmodule

`default_nettype wire
